// ===== sv/utf8wct_pkg.sv =====
// utf8wct_pkg: types, constants and helpers for the utf-8 whole-character truncator
// no dependencies; imported by utf8_whole_char_truncator
`default_nettype none

package utf8wct_pkg;

  // size of the destination buffer, terminator included
  localparam int BufferBytes = 4096;
  // byte capacity never exceeds buffer size minus the terminator
  localparam logic [11:0] CapLimit =
    (BufferBytes - 1 < 4095) ? 12'(BufferBytes - 1) : 12'd4095;

  // lead and continuation byte masks
  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] ContMask   = 8'hC0;
  localparam logic [7:0] ContCode   = 8'h80;
  localparam logic [7:0] Lead2Mask  = 8'hE0;
  localparam logic [7:0] Lead2Code  = 8'hC0;
  localparam logic [7:0] Lead3Mask  = 8'hF0;
  localparam logic [7:0] Lead3Code  = 8'hE0;
  localparam logic [7:0] Lead4Mask  = 8'hF8;
  localparam logic [7:0] Lead4Code  = 8'hF0;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxBytes   = 2'd0,
    CfgMaxChars   = 2'd1,
    CfgCharLimEn  = 2'd2
  } cfg_idx_e;

  // character length announced by a lead byte; bad leads stand alone
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd1;
    if (b < AsciiLimit) len = 3'd1;
    else if ((b & Lead2Mask) == Lead2Code) len = 3'd2;
    else if ((b & Lead3Mask) == Lead3Code) len = 3'd3;
    else if ((b & Lead4Mask) == Lead4Code) len = 3'd4;
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== sv/utf8_whole_char_truncator.sv =====
// utf8_whole_char_truncator: copies whole utf-8 characters of a zero-terminated stream
// depends on utf8wct_pkg
// path: input register, then burst register; throughput: one byte per cycle while
//   the output is not stalled and each byte gives at most one word; a byte that gives
//   k words (up to 4) holds the single output register until all k words have left
// reset: asynchronous active low; clears all counters and buffers, registers go to
//   max_bytes 4095, max_chars 65535, char limit enabled
`default_nettype none

module utf8_whole_char_truncator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input byte channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        byte_value_i,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [utf8wct_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [utf8wct_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [7:0]                        out_byte_o,
  output logic                              is_terminator_o,
  output logic [11:0]                       chars_copied_o,
  output logic [15:0]                       total_chars_o,
  output logic                              run_last_o
);
  import utf8wct_pkg::*;

  // configuration registers
  logic [11:0] max_bytes_q;
  logic [15:0] max_chars_q;
  logic        char_lim_en_q;
  logic [11:0] cap;

  // input register
  logic        in_valid_q;
  logic [7:0]  in_byte_q;

  // character assembly state
  logic [7:0]  pend_q [3];
  logic [7:0]  pend_d [3];
  logic [1:0]  pcnt_q, pcnt_d;
  logic [2:0]  explen_q, explen_d;
  logic [11:0] bw_q, bw_d;
  logic [11:0] cw_q, cw_d;
  logic [15:0] tot_q, tot_d;
  logic        stop_q, stop_d;

  // output burst register
  logic [7:0]  burst_byte_q [4];
  logic [2:0]  burst_n_q;
  logic [1:0]  burst_idx_q;
  logic        burst_term_q;
  logic [11:0] burst_copied_q;
  logic [15:0] burst_total_q;

  // decode and character step signals
  logic        is_term, is_cont;
  logic [2:0]  lead;
  logic [2:0]  flush_v;
  logic        fin_v;
  logic [2:0]  fin_len;
  logic [7:0]  fin_byte [4];
  logic        slot_v;
  logic [2:0]  slot_len;
  logic [7:0]  slot_byte [4];
  logic [11:0] bw_upd, cw_upd;
  logic [15:0] tot_upd;
  logic        stop_upd;
  logic [7:0]  res_byte [4];
  logic [2:0]  res_n;

  // handshake
  logic        in_accept, advance, out_fire, burst_last;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q   <= 12'd4095;
      max_chars_q   <= 16'hFFFF;
      char_lim_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgMaxBytes:  max_bytes_q   <= cfg_wdata_i[11:0];
        CfgMaxChars:  max_chars_q   <= cfg_wdata_i[15:0];
        CfgCharLimEn: char_lim_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cap = (max_bytes_q > CapLimit) ? CapLimit : max_bytes_q;

  // handshake control
  assign burst_last  = ({1'b0, burst_idx_q} + 3'd1) == burst_n_q;
  assign out_valid_o = burst_n_q != 3'd0;
  assign out_fire    = out_valid_o && !out_stall_i;
  assign advance     = in_valid_q && ((burst_n_q == 3'd0) || (out_fire && burst_last));
  assign in_stall_o  = in_valid_q && !advance;
  assign in_accept   = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_byte_q  <= 8'h00;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
      in_byte_q  <= byte_value_i;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // split the byte into flushed single bytes and at most one finished character
  always_comb begin
    is_term  = in_byte_q == 8'h00;
    is_cont  = (in_byte_q & ContMask) == ContCode;
    lead     = lead_len(in_byte_q);
    flush_v  = 3'b000;
    fin_v    = 1'b0;
    fin_len  = 3'd1;
    for (int i = 0; i < 4; i++) fin_byte[i] = 8'h00;
    for (int i = 0; i < 3; i++) pend_d[i] = pend_q[i];
    pcnt_d   = pcnt_q;
    explen_d = explen_q;
    if (is_term) begin
      // terminator: buffered bytes become single characters
      for (int i = 0; i < 3; i++) flush_v[i] = 2'(i) < pcnt_q;
      for (int i = 0; i < 3; i++) pend_d[i] = 8'h00;
      pcnt_d   = 2'd0;
      explen_d = 3'd0;
    end else if (pcnt_q != 2'd0 && is_cont) begin
      if (({1'b0, pcnt_q} + 3'd1) >= explen_q) begin
        // character complete
        fin_v   = 1'b1;
        fin_len = {1'b0, pcnt_q} + 3'd1;
        for (int i = 0; i < 3; i++) fin_byte[i] = pend_q[i];
        fin_byte[pcnt_q] = in_byte_q;
        pcnt_d   = 2'd0;
        explen_d = 3'd0;
      end else begin
        pend_d[pcnt_q] = in_byte_q;
        pcnt_d         = pcnt_q + 2'd1;
      end
    end else begin
      // broken sequence flushes, then the byte is a fresh lead
      for (int i = 0; i < 3; i++) flush_v[i] = 2'(i) < pcnt_q;
      if (lead == 3'd1) begin
        fin_v       = 1'b1;
        fin_byte[0] = in_byte_q;
        pcnt_d      = 2'd0;
        explen_d    = 3'd0;
      end else begin
        pend_d[0] = in_byte_q;
        pcnt_d    = 2'd1;
        explen_d  = lead;
      end
    end
  end

  // count and copy up to four characters in order
  always_comb begin
    bw_upd   = bw_q;
    cw_upd   = cw_q;
    tot_upd  = tot_q;
    stop_upd = stop_q;
    res_n    = 3'd0;
    slot_v   = 1'b0;
    slot_len = 3'd1;
    for (int i = 0; i < 4; i++) res_byte[i] = 8'h00;
    for (int i = 0; i < 4; i++) slot_byte[i] = 8'h00;
    for (int s = 0; s < 4; s++) begin
      if (s < 3) begin
        slot_v       = flush_v[s];
        slot_len     = 3'd1;
        slot_byte[0] = pend_q[s];
        for (int j = 1; j < 4; j++) slot_byte[j] = 8'h00;
      end else begin
        slot_v   = fin_v;
        slot_len = fin_len;
        for (int j = 0; j < 4; j++) slot_byte[j] = fin_byte[j];
      end
      if (slot_v) begin
        if (tot_upd != 16'hFFFF) tot_upd = tot_upd + 16'd1;
        if (!stop_upd) begin
          if ((char_lim_en_q && ({4'b0, cw_upd} >= max_chars_q)) ||
              (({1'b0, bw_upd} + {10'b0, slot_len}) > {1'b0, cap})) begin
            stop_upd = 1'b1;
          end else begin
            for (int j = 0; j < 4; j++) begin
              if (3'(j) < slot_len) begin
                res_byte[res_n[1:0]] = slot_byte[j];
                res_n = res_n + 3'd1;
              end
            end
            bw_upd = bw_upd + {9'b0, slot_len};
            cw_upd = cw_upd + 12'd1;
          end
        end
      end
    end
    // terminator word closes the burst
    if (is_term) begin
      res_byte[res_n[1:0]] = 8'h00;
      res_n = res_n + 3'd1;
    end
  end

  // counters restart after a terminator
  always_comb begin
    if (is_term) begin
      bw_d   = 12'd0;
      cw_d   = 12'd0;
      tot_d  = 16'd0;
      stop_d = 1'b0;
    end else begin
      bw_d   = bw_upd;
      cw_d   = cw_upd;
      tot_d  = tot_upd;
      stop_d = stop_upd;
    end
  end

  // assembly state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) pend_q[i] <= 8'h00;
      pcnt_q   <= 2'd0;
      explen_q <= 3'd0;
      bw_q     <= 12'd0;
      cw_q     <= 12'd0;
      tot_q    <= 16'd0;
      stop_q   <= 1'b0;
    end else if (advance) begin
      for (int i = 0; i < 3; i++) pend_q[i] <= pend_d[i];
      pcnt_q   <= pcnt_d;
      explen_q <= explen_d;
      bw_q     <= bw_d;
      cw_q     <= cw_d;
      tot_q    <= tot_d;
      stop_q   <= stop_d;
    end
  end

  // burst register, drained one word per cycle while the output is not stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_n_q      <= 3'd0;
      burst_idx_q    <= 2'd0;
      burst_term_q   <= 1'b0;
      burst_copied_q <= 12'd0;
      burst_total_q  <= 16'd0;
      for (int i = 0; i < 4; i++) burst_byte_q[i] <= 8'h00;
    end else if (advance) begin
      burst_n_q      <= res_n;
      burst_idx_q    <= 2'd0;
      burst_term_q   <= is_term;
      burst_copied_q <= cw_upd;
      burst_total_q  <= tot_upd;
      for (int i = 0; i < 4; i++) burst_byte_q[i] <= res_byte[i];
    end else if (out_fire) begin
      if (burst_last) begin
        burst_n_q   <= 3'd0;
        burst_idx_q <= 2'd0;
      end else begin
        burst_idx_q <= burst_idx_q + 2'd1;
      end
    end
  end

  // result word fields
  assign out_byte_o      = burst_byte_q[burst_idx_q];
  assign is_terminator_o = burst_term_q && burst_last;
  assign chars_copied_o  = is_terminator_o ? burst_copied_q : 12'd0;
  assign total_chars_o   = is_terminator_o ? burst_total_q : 16'd0;
  assign run_last_o      = burst_last;

endmodule

`default_nettype wire

// ===== sv/utf8wct_checker.sv =====
// utf8wct_checker: port-level assertions for utf8_whole_char_truncator
// watches the result channel only; bound to the top level below
`default_nettype none

module utf8wct_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [7:0]                        out_byte_o,
  input logic                              is_terminator_o,
  input logic [11:0]                       chars_copied_o,
  input logic [15:0]                       total_chars_o,
  input logic                              run_last_o
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
      $stable(is_terminator_o) && $stable(run_last_o))
    else $error("stalled result word changed");

  // the terminator closes its byte's burst and carries a zero byte
  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_terminator_o |-> run_last_o && out_byte_o == 8'h00)
    else $error("terminator word malformed");

  // counts appear only on the terminator
  a_counts_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_terminator_o |-> chars_copied_o == 12'd0 && total_chars_o == 16'd0)
    else $error("counts on a data word");

  // every copied character was also counted
  a_copied_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_terminator_o |-> {4'b0, chars_copied_o} <= total_chars_o)
    else $error("copied count exceeds total count");

  // a copied byte is never zero
  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_terminator_o |-> out_byte_o != 8'h00)
    else $error("zero byte in copied data");

endmodule

bind utf8_whole_char_truncator utf8wct_checker u_utf8wct_checker (.*);

`default_nettype wire
